[rtl/core/pntf_pkg.sv]
// Shared types, codes and defaults for the paced notify transmit FIFO.
// Used by every module of the block except pntf_ram; depends on nothing.
package pntf_pkg;

    localparam int FIFO_DEPTH_DEF  = 1024;
    localparam int CHUNK_BYTES_DEF = 20;
    localparam int CMDQ_DEPTH      = 2;
    localparam int CMDQ_PTR_W      = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W      = $clog2(CMDQ_DEPTH + 1);
    localparam int MS_W            = 16;
    localparam int CFG_DATA_W      = 12;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_OUT_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADV_DELAY   = 2'd2;

    localparam logic        DATA_OUT_EN_RST = 1'b0;
    localparam logic [7:0]  TX_INTERVAL_RST = 8'd12;
    localparam logic [11:0] ADV_DELAY_RST   = 12'd500;

    typedef enum logic [1:0] {
        REQ_TICK       = 2'd0,
        REQ_WRITE      = 2'd1,
        REQ_CONNECT    = 2'd2,
        REQ_DISCONNECT = 2'd3
    } req_e_t;

    typedef enum logic [1:0] {
        KIND_ACK       = 2'd0,
        KIND_NOTIFY    = 2'd1,
        KIND_ADV_START = 2'd2,
        KIND_ADV_STOP  = 2'd3
    } kind_e_t;

    typedef struct packed {
        req_e_t     req;
        logic [7:0] data;
        logic       eow;
    } cmd_t;

    typedef struct packed {
        logic        data_out_en;
        logic [7:0]  tx_interval;
        logic [11:0] adv_delay;
    } cfg_t;

    function automatic logic [MS_W-1:0] sat_inc(input logic [MS_W-1:0] v);
        return (v == '1) ? v : MS_W'(v + 1'b1);
    endfunction

endpackage

[rtl/core/pntf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module pntf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/pntf_front.sv]
// Front end: accepts input requests, decodes them into commands and queues them.
// Depends on pntf_pkg.
module pntf_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_req_type,
    input  logic [7:0]        s_data_byte,
    input  logic              s_end_of_write,
    output pntf_pkg::cmd_t    cmd,
    output logic              cmd_valid,
    input  logic              cmd_ready
);
    import pntf_pkg::*;

    cmd_t                  q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;
    cmd_t                  in_cmd;
    logic                  push, pop;

    always_comb begin
        in_cmd.req  = req_e_t'(s_req_type);
        in_cmd.data = s_data_byte;
        in_cmd.eow  = s_end_of_write;
    end

    assign s_ready   = (count_reg != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? CMDQ_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? CMDQ_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = CMDQ_CNT_W'(count_reg + 1'b1);
        end else if (pop && !push) begin
            count_next = CMDQ_CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[rtl/core/pntf_back.sv]
// Back end: executes queued commands against the byte ring buffer and link state,
// and drives the registered result channel. Depends on pntf_pkg and pntf_ram.
module pntf_back #(
    parameter int FIFO_DEPTH  = pntf_pkg::FIFO_DEPTH_DEF,
    parameter int CHUNK_BYTES = pntf_pkg::CHUNK_BYTES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pntf_pkg::cmd_t    cmd,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  pntf_pkg::cfg_t    cfg,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_result_kind,
    output logic [7:0]        m_out_byte,
    output logic              m_accepted,
    output logic              m_last
);
    import pntf_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(CHUNK_BYTES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADV,
        ST_RD,
        ST_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic            link_up_reg, link_up_next;
    logic            link_was_up_reg, link_was_up_next;
    logic            adv_on_reg, adv_on_next;
    logic            refusing_reg, refusing_next;
    logic [MS_W-1:0] since_chunk_reg, since_chunk_next;
    logic [MS_W-1:0] since_drop_reg, since_drop_next;
    kind_e_t         adv_kind_reg, adv_kind_next;
    logic            drain_pend_reg, drain_pend_next;
    logic [CW-1:0]   chunk_cnt_reg, chunk_cnt_next;
    logic            m_valid_reg, m_valid_next;
    kind_e_t         kind_reg, kind_next;
    logic [7:0]      byte_reg, byte_next;
    logic            acc_reg, acc_next;
    logic            last_reg, last_next;

    logic            out_free;
    logic [AW-1:0]   wr_inc, rd_inc;
    logic            room;
    logic            ram_we;
    logic [7:0]      ram_rdata;
    logic [MS_W-1:0] chunk_inc, drop_inc;
    logic            fall, rise, was_up_after, adv_start, adv_stop, drain_go;
    logic            byte_ok, last_byte;

    pntf_ram #(
        .WIDTH(8),
        .DEPTH(FIFO_DEPTH)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(wr_ptr_reg),
        .wdata(cmd.data),
        .raddr(rd_ptr_reg),
        .rdata(ram_rdata)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign wr_inc    = (wr_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : AW'(wr_ptr_reg + 1'b1);
    assign rd_inc    = (rd_ptr_reg == AW'(FIFO_DEPTH - 1)) ? '0 : AW'(rd_ptr_reg + 1'b1);
    assign room      = (wr_inc != rd_ptr_reg);
    assign cmd_ready = (state_reg == ST_IDLE) && ((cmd.req != REQ_WRITE) || out_free);

    assign chunk_inc    = sat_inc(since_chunk_reg);
    assign drop_inc     = sat_inc(since_drop_reg);
    assign fall         = !link_up_reg && link_was_up_reg;
    assign rise         = link_up_reg && !link_was_up_reg;
    assign was_up_after = fall ? 1'b0 : link_was_up_reg;
    assign adv_start    = !link_up_reg && !was_up_after && !adv_on_reg
                          && (drop_inc > MS_W'(cfg.adv_delay));
    assign adv_stop     = rise && adv_on_reg;
    assign drain_go     = link_up_reg && (chunk_inc >= MS_W'(cfg.tx_interval))
                          && (rd_ptr_reg != wr_ptr_reg);
    assign byte_ok      = !refusing_reg && cfg.data_out_en && room;
    assign last_byte    = (chunk_cnt_reg == CW'(CHUNK_BYTES - 1)) || (rd_inc == wr_ptr_reg);

    always_comb begin
        state_next       = state_reg;
        wr_ptr_next      = wr_ptr_reg;
        rd_ptr_next      = rd_ptr_reg;
        link_up_next     = link_up_reg;
        link_was_up_next = link_was_up_reg;
        adv_on_next      = adv_on_reg;
        refusing_next    = refusing_reg;
        since_chunk_next = since_chunk_reg;
        since_drop_next  = since_drop_reg;
        adv_kind_next    = adv_kind_reg;
        drain_pend_next  = drain_pend_reg;
        chunk_cnt_next   = chunk_cnt_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        kind_next        = kind_reg;
        byte_next        = byte_reg;
        acc_next         = acc_reg;
        last_next        = last_reg;
        ram_we           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && cmd_ready) begin
                    unique case (cmd.req)
                        REQ_WRITE: begin
                            ram_we        = byte_ok;
                            wr_ptr_next   = byte_ok ? wr_inc : wr_ptr_reg;
                            refusing_next = cmd.eow ? 1'b0 : !byte_ok || refusing_reg;
                            m_valid_next  = 1'b1;
                            kind_next     = KIND_ACK;
                            byte_next     = '0;
                            acc_next      = byte_ok;
                            last_next     = 1'b1;
                        end
                        REQ_CONNECT: begin
                            link_up_next = 1'b1;
                        end
                        REQ_DISCONNECT: begin
                            link_up_next    = 1'b0;
                            since_drop_next = '0;
                        end
                        REQ_TICK: begin
                            since_chunk_next = drain_go ? '0 : chunk_inc;
                            since_drop_next  = drop_inc;
                            link_was_up_next = rise ? 1'b1 : was_up_after;
                            if (fall) begin
                                wr_ptr_next = '0;
                                rd_ptr_next = '0;
                            end
                            if (adv_start) begin
                                adv_on_next = 1'b1;
                            end else if (adv_stop) begin
                                adv_on_next = 1'b0;
                            end
                            adv_kind_next   = adv_start ? KIND_ADV_START : KIND_ADV_STOP;
                            drain_pend_next = drain_go;
                            chunk_cnt_next  = '0;
                            if (adv_start || adv_stop) begin
                                state_next = ST_ADV;
                            end else if (drain_go) begin
                                state_next = ST_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADV: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = adv_kind_reg;
                    byte_next    = '0;
                    acc_next     = 1'b0;
                    last_next    = !drain_pend_reg;
                    state_next   = drain_pend_reg ? ST_RD : ST_IDLE;
                end
            end
            ST_RD: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    kind_next      = KIND_NOTIFY;
                    byte_next      = ram_rdata;
                    acc_next       = 1'b0;
                    last_next      = last_byte;
                    rd_ptr_next    = rd_inc;
                    chunk_cnt_next = CW'(chunk_cnt_reg + 1'b1);
                    state_next     = last_byte ? ST_IDLE : ST_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            link_up_reg     <= 1'b0;
            link_was_up_reg <= 1'b0;
            adv_on_reg      <= 1'b1;
            refusing_reg    <= 1'b0;
            since_chunk_reg <= '1;
            since_drop_reg  <= '0;
            adv_kind_reg    <= KIND_ADV_START;
            drain_pend_reg  <= 1'b0;
            chunk_cnt_reg   <= '0;
            m_valid_reg     <= 1'b0;
            kind_reg        <= KIND_ACK;
            byte_reg        <= '0;
            acc_reg         <= 1'b0;
            last_reg        <= 1'b0;
        end else begin
            state_reg       <= state_next;
            wr_ptr_reg      <= wr_ptr_next;
            rd_ptr_reg      <= rd_ptr_next;
            link_up_reg     <= link_up_next;
            link_was_up_reg <= link_was_up_next;
            adv_on_reg      <= adv_on_next;
            refusing_reg    <= refusing_next;
            since_chunk_reg <= since_chunk_next;
            since_drop_reg  <= since_drop_next;
            adv_kind_reg    <= adv_kind_next;
            drain_pend_reg  <= drain_pend_next;
            chunk_cnt_reg   <= chunk_cnt_next;
            m_valid_reg     <= m_valid_next;
            kind_reg        <= kind_next;
            byte_reg        <= byte_next;
            acc_reg         <= acc_next;
            last_reg        <= last_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = kind_reg;
    assign m_out_byte    = byte_reg;
    assign m_accepted    = acc_reg;
    assign m_last        = last_reg;

endmodule

[rtl/core/paced_notify_tx_fifo.sv]
// Paced notify transmit FIFO: byte ring buffer drained in chunks on millisecond ticks.
// Path: a write acknowledge passes the front-end queue, then the result register;
// a tick's advertising result leaves from ADV, its notify bytes from RD then EMIT.
// Throughput: writes and link events run at one per cycle while the back end is idle,
// writes also only while the result slot is free; notify bytes go out one at a time.
// Reset: synchronous; the byte store is not cleared and needs no pass.
module paced_notify_tx_fifo #(
    parameter int FIFO_DEPTH  = pntf_pkg::FIFO_DEPTH_DEF,
    parameter int CHUNK_BYTES = pntf_pkg::CHUNK_BYTES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pntf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pntf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_req_type,
    input  logic [7:0]                      s_data_byte,
    input  logic                            s_end_of_write,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_result_kind,
    output logic [7:0]                      m_out_byte,
    output logic                            m_accepted,
    output logic                            m_last
);
    import pntf_pkg::*;

    cfg_t cfg_reg, cfg_next;
    cmd_t cmd;
    logic cmd_valid, cmd_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_DATA_OUT_EN: cfg_next.data_out_en = cfg_wdata[0];
                CFG_TX_INTERVAL: cfg_next.tx_interval = cfg_wdata[7:0];
                CFG_ADV_DELAY:   cfg_next.adv_delay   = cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.data_out_en <= DATA_OUT_EN_RST;
            cfg_reg.tx_interval <= TX_INTERVAL_RST;
            cfg_reg.adv_delay   <= ADV_DELAY_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    pntf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_data_byte   (s_data_byte),
        .s_end_of_write(s_end_of_write),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready)
    );

    pntf_back #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .CHUNK_BYTES(CHUNK_BYTES)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cfg          (cfg_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_result_kind(m_result_kind),
        .m_out_byte   (m_out_byte),
        .m_accepted   (m_accepted),
        .m_last       (m_last)
    );

    a_ack_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind == KIND_ACK)) |-> m_last)
        else $error("write acknowledge not marked last");

    a_accepted_only_on_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind != KIND_ACK)) |-> !m_accepted)
        else $error("accepted flag set on a non-acknowledge result");

    a_byte_only_on_notify: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_result_kind != KIND_NOTIFY)) |-> (m_out_byte == 8'd0))
        else $error("nonzero byte on a non-notify result");

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

[test/paced_notify_tx_fifo_tb.sv]
// Self-checking testbench for paced_notify_tx_fifo: directed script, receiver stall, random phases.
// Results are predicted by an in-bench shadow of the ring buffer and link logic.
// Depends on pntf_pkg and the paced_notify_tx_fifo RTL only.
module paced_notify_tx_fifo_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pntf_pkg::*;

    localparam int DEPTH         = FIFO_DEPTH_DEF;
    localparam int CHUNK         = CHUNK_BYTES_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 100;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int PH_EN [PHASES] = '{1, 1, 0, 1, 1, 1, 1};
    localparam int PH_IV [PHASES] = '{0, 3, 1, 0, 255, 0, 0};
    localparam int PH_DL [PHASES] = '{2, 0, 5, 0, 4095, 0, 1};

    typedef struct packed {
        kind_e_t    kind;
        logic [7:0] data;
        logic       acc;
        logic       last;
    } tx_result_t;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        req_e_t                req;
        logic [7:0]            data;
        logic                  eow;
        logic                  typed;
        logic                  acc;
    } script_row_t;

    localparam int SCRIPT_LEN = 33;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_WRITE,      8'hFF, 1'b1, 1'b1, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_TICK,       8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b1, CFG_DATA_OUT_EN, 12'hFFF, REQ_TICK,       8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b1, CFG_SPARE,       12'h000, REQ_TICK,       8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_WRITE,      8'h00, 1'b0, 1'b1, 1'b1},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_WRITE,      8'hFF, 1'b1, 1'b1, 1'b1},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_WRITE,      8'hA5, 1'b1, 1'b1, 1'b1},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_CONNECT,    8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_TICK,       8'hFF, 1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_TICK,       8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b1, CFG_TX_INTERVAL, 12'hF00, REQ_TICK,       8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_WRITE,      8'h5A, 1'b1, 1'b1, 1'b1},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_TICK,       8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_TICK,       8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b1, CFG_DATA_OUT_EN, 12'hFFE, REQ_TICK,       8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_WRITE,      8'h11, 1'b0, 1'b1, 1'b0},
        '{1'b1, CFG_DATA_OUT_EN, 12'h001, REQ_TICK,       8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_WRITE,      8'h22, 1'b0, 1'b1, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_WRITE,      8'h33, 1'b1, 1'b1, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_WRITE,      8'h44, 1'b1, 1'b1, 1'b1},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_DISCONNECT, 8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b1, CFG_ADV_DELAY,   12'h000, REQ_TICK,       8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_TICK,       8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_DISCONNECT, 8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b1, CFG_ADV_DELAY,   12'hFFF, REQ_TICK,       8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_CONNECT,    8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_TICK,       8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_DISCONNECT, 8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_TICK,       8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b1, CFG_TX_INTERVAL, 12'h0FF, REQ_TICK,       8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_CONNECT,    8'h00, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_WRITE,      8'h80, 1'b1, 1'b1, 1'b1},
        '{1'b0, CFG_DATA_OUT_EN, 12'h000, REQ_TICK,       8'h00, 1'b0, 1'b0, 1'b0}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_req_type;
    logic [7:0]            s_data_byte;
    logic                  s_end_of_write;
    logic                  m_valid;
    logic                  m_ready;
    logic [1:0]            m_result_kind;
    logic [7:0]            m_out_byte;
    logic                  m_accepted;
    logic                  m_last;

    // Shadow of the block state and its registers.
    logic [7:0]  byte_ring [DEPTH];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    bit          link_up;
    bit          link_was_up;
    bit          adv_on;
    bit          refusing;
    logic [15:0] ms_chunk;
    logic [15:0] ms_drop;
    logic        reg_en;
    logic [7:0]  reg_iv;
    logic [11:0] reg_dl;

    tx_result_t owed [$];

    int  mismatches;
    int  sent_requests;
    int  seen_results;
    int  seen_notify;
    int  seen_adv;
    int  idle_cycles;
    int  hold_request;
    bit  sender_gaps;
    bit  receiver_stalls;

    paced_notify_tx_fifo dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_data_byte    (s_data_byte),
        .s_end_of_write (s_end_of_write),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_out_byte     (m_out_byte),
        .m_accepted     (m_accepted),
        .m_last         (m_last)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Applies one accepted request to the shadow state and queues the results it causes.
    function automatic void fifo_link_step(input req_e_t req, input logic [7:0] d,
                                           input logic eow);
        tx_result_t r;
        int         first;
        int         drained;
        first = owed.size();
        case (req)
            REQ_WRITE: begin
                r = '{KIND_ACK, 8'h00, 1'b0, 1'b0};
                if (!refusing && reg_en &&
                    ((wr_ptr + DEPTH - rd_ptr) % DEPTH) < DEPTH - 1) begin
                    byte_ring[wr_ptr] = d;
                    wr_ptr = (wr_ptr + 1) % DEPTH;
                    r.acc = 1'b1;
                end else begin
                    refusing = 1'b1;
                end
                if (eow) begin
                    refusing = 1'b0;
                end
                owed.push_back(r);
            end
            REQ_CONNECT: begin
                link_up = 1'b1;
            end
            REQ_DISCONNECT: begin
                link_up = 1'b0;
                ms_drop = 16'd0;
            end
            default: begin
                if (ms_chunk != 16'hFFFF) begin
                    ms_chunk = ms_chunk + 16'd1;
                end
                if (ms_drop != 16'hFFFF) begin
                    ms_drop = ms_drop + 16'd1;
                end
                if (!link_up && link_was_up) begin
                    link_was_up = 1'b0;
                    wr_ptr = 0;
                    rd_ptr = 0;
                end
                if (!link_up && !link_was_up && ms_drop > reg_dl && !adv_on) begin
                    adv_on = 1'b1;
                    owed.push_back('{KIND_ADV_START, 8'h00, 1'b0, 1'b0});
                end
                if (link_up && !link_was_up) begin
                    link_was_up = 1'b1;
                    if (adv_on) begin
                        adv_on = 1'b0;
                        owed.push_back('{KIND_ADV_STOP, 8'h00, 1'b0, 1'b0});
                    end
                end
                if (link_up && ms_chunk >= reg_iv) begin
                    drained = 0;
                    while (drained < CHUNK && rd_ptr != wr_ptr) begin
                        owed.push_back('{KIND_NOTIFY, byte_ring[rd_ptr], 1'b0, 1'b0});
                        rd_ptr = (rd_ptr + 1) % DEPTH;
                        drained++;
                    end
                    if (drained > 0) begin
                        ms_chunk = 16'd0;
                    end
                end
            end
        endcase
        if (owed.size() > first) begin
            r = owed.pop_back();
            r.last = 1'b1;
            owed.push_back(r);
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DATA_OUT_EN: reg_en = val[0];
            CFG_TX_INTERVAL: reg_iv = val[7:0];
            CFG_ADV_DELAY:   reg_dl = val[11:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic program_regs(input int en, input int iv, input int dl);
        write_reg(CFG_DATA_OUT_EN, CFG_DATA_W'(en));
        write_reg(CFG_TX_INTERVAL, CFG_DATA_W'(iv));
        write_reg(CFG_ADV_DELAY, CFG_DATA_W'(dl));
    endtask

    task automatic quiesce();
        s_valid <= 1'b0;
        while (owed.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_request(input req_e_t req, input logic [7:0] d, input logic eow,
                                input logic typed, input logic acc);
        tx_result_t r;
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_req_type     <= req;
        s_data_byte    <= d;
        s_end_of_write <= eow;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        fifo_link_step(req, d, eow);
        if (typed) begin
            r = owed.pop_back();
            r.acc = acc;
            owed.push_back(r);
        end
        sent_requests++;
    endtask

    task automatic send_call(input int len, input bit broken);
        for (int k = 0; k < len; k++) begin
            send_request(REQ_WRITE, 8'($urandom),
                         broken ? 1'($urandom) : logic'(k == len - 1), 1'b0, 1'b0);
        end
    endtask

    task automatic tick_burst(input int n);
        repeat (n) send_request(REQ_TICK, 8'($urandom), 1'($urandom), 1'b0, 1'b0);
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        tx_result_t want;
        if (aresetn && m_valid && m_ready) begin
            seen_results++;
            if (m_result_kind == KIND_NOTIFY) begin
                seen_notify++;
            end else if (m_result_kind != KIND_ACK) begin
                seen_adv++;
            end
            if (owed.size() == 0) begin
                $display("%0t ns: result expected none, got kind %0d byte %0h acc %0b last %0b",
                         $time, m_result_kind, m_out_byte, m_accepted, m_last);
                mismatches++;
            end else begin
                want = owed.pop_front();
                check_field("result_kind", want.kind, m_result_kind);
                check_field("out_byte", want.data, m_out_byte);
                check_field("accepted", want.acc, m_accepted);
                check_field("last", want.last, m_last);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no request moved for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) begin
            @(posedge aclk);
        end
        forever begin
            if (hold_request > 0) begin
                m_ready <= 1'b0;
                repeat (hold_request) @(posedge aclk);
                hold_request = 0;
            end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin
        int pick;
        int budget;
        int iv;
        int dl;

        aresetn        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_DATA_OUT_EN;
        cfg_wdata      <= '0;
        s_valid        <= 1'b0;
        s_req_type     <= REQ_TICK;
        s_data_byte    <= 8'h00;
        s_end_of_write <= 1'b0;

        wr_ptr          = 0;
        rd_ptr          = 0;
        link_up         = 1'b0;
        link_was_up     = 1'b0;
        adv_on          = 1'b1;
        refusing        = 1'b0;
        ms_chunk        = 16'hFFFF;
        ms_drop         = 16'd0;
        reg_en          = DATA_OUT_EN_RST;
        reg_iv          = TX_INTERVAL_RST;
        reg_dl          = ADV_DELAY_RST;
        mismatches      = 0;
        sent_requests   = 0;
        seen_results    = 0;
        seen_notify     = 0;
        seen_adv        = 0;
        idle_cycles     = 0;
        hold_request    = 0;
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (SCRIPT[i]) begin
            if (SCRIPT[i].is_cfg) begin
                quiesce();
                write_reg(SCRIPT[i].idx, SCRIPT[i].val);
            end else begin
                send_request(SCRIPT[i].req, SCRIPT[i].data, SCRIPT[i].eow,
                             SCRIPT[i].typed, SCRIPT[i].acc);
            end
        end

        // Back up the input while the receiver holds off, then drain the stored bytes in chunks.
        quiesce();
        program_regs(1, 0, 3);
        hold_request = HOLD_CYCLES;
        send_request(REQ_CONNECT, 8'h00, 1'b0, 1'b0, 1'b0);
        tick_burst(2);
        repeat (3) send_call(8, 1'b0);
        tick_burst(1);
        for (int t = 0; t < 4; t++) begin
            tick_burst(1);
        end
        send_request(REQ_DISCONNECT, 8'h00, 1'b0, 1'b0, 1'b0);
        send_call(3, 1'b0);
        tick_burst(1);

        for (int ph = 0; ph < PHASES; ph++) begin
            quiesce();
            if (ph == PHASES - 1) begin
                sender_gaps     = 1'b0;
                receiver_stalls = 1'b0;
            end
            iv = PH_IV[ph];
            dl = PH_DL[ph];
            if (ph == 3 || ph == 5) begin
                iv = $urandom_range(0, 6);
                dl = $urandom_range(0, 8);
            end
            program_regs(PH_EN[ph], iv, dl);
            budget = sent_requests + PHASE_ITEMS;
            while (sent_requests < budget) begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    send_call($urandom_range(1, 6), 1'b0);
                end else if (pick < 58) begin
                    send_call($urandom_range(1, 4), 1'b1);
                end else if (pick < 78) begin
                    tick_burst(1);
                end else if (pick < 90) begin
                    send_request(REQ_CONNECT, 8'($urandom), 1'($urandom), 1'b0, 1'b0);
                    tick_burst($urandom_range(1, 3));
                end else begin
                    send_request(REQ_DISCONNECT, 8'($urandom), 1'($urandom), 1'b0, 1'b0);
                    tick_burst($urandom_range(1, 8));
                end
            end
        end

        quiesce();
        $display("Covered %0d requests and %0d results: %0d notify bytes, %0d advertising changes.",
                 sent_requests, seen_results, seen_notify, seen_adv);
        $display("Included refused calls, a long receiver stall, link drops and register extremes.");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
